// File: rtl/core/iwlf_pkg.sv
// ----------------------------------------------------------------------------
// iwlf_pkg
// Shared types and constants for the incremental weighted line fit core.
// ----------------------------------------------------------------------------
package iwlf_pkg;

	localparam int MaxHits = 32;
	localparam int IdxW    = $clog2(MaxHits);
	localparam int CntW    = $clog2(MaxHits + 1);
	localparam int WideW   = 128;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_SOLVED   = 2'd0,
		ST_FEW      = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// divider request and response
	typedef struct packed {
		logic               start;
		logic [WideW-1:0]   num;
		logic [WideW-1:0]   den;
		logic               narrow;   // saturate to 24 bits, else 32
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [31:0]        quot;
	} div_rsp_t;

endpackage

// File: rtl/core/iwlf_div.sv
// ----------------------------------------------------------------------------
// iwlf_div
// Shared signed restoring divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module iwlf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  iwlf_pkg::div_req_t req,
	output iwlf_pkg::div_rsp_t rsp
);
	import iwlf_pkg::*;

	logic [WideW-1:0] num_q, den_q, rem_q, quo_q;
	logic [7:0]       cnt_q;
	logic             busy_q, neg_q, narrow_q, done_q;
	logic [WideW:0]   rem_sh, rem_sub;
	logic [WideW-1:0] qmag;
	logic             ovf;
	logic [31:0]      res;

	// shift in one numerator bit and trial-subtract
	assign rem_sh  = {rem_q, num_q[WideW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// saturate final quotient
	always_comb begin
		qmag = quo_q;
		if (narrow_q) begin
			ovf = (qmag[WideW-1:23] != '0);
			if (neg_q) res = ovf ? 32'hFF80_0000 : 32'(-qmag[31:0]);
			else       res = ovf ? 32'h007F_FFFF : qmag[31:0];
		end else begin
			ovf = (qmag[WideW-1:31] != '0);
			if (neg_q) res = ovf ? 32'h8000_0000 : 32'(-qmag[31:0]);
			else       res = ovf ? 32'h7FFF_FFFF : qmag[31:0];
		end
	end

	// iterate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 8'(WideW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q    <= req.num[WideW-1] ? -req.num : req.num;
			den_q    <= req.den[WideW-1] ? -req.den : req.den;
			neg_q    <= req.num[WideW-1] ^ req.den[WideW-1];
			narrow_q <= req.narrow;
			rem_q    <= '0;
			quo_q    <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!rem_sub[WideW]) begin
				rem_q <= rem_sub[WideW-1:0];
				quo_q <= {quo_q[WideW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[WideW-1:0];
				quo_q <= {quo_q[WideW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = res;

endmodule

// File: rtl/core/iwlf_mul.sv
// ----------------------------------------------------------------------------
// iwlf_mul
// Shared signed 64 x 64 multiplier, accumulating four 32 x 32 partial products.
// ----------------------------------------------------------------------------
module iwlf_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	output logic          done,
	output logic [127:0]  prod
);
	import iwlf_pkg::*;

	logic [63:0]  ua_q, ub_q;
	logic         neg_q, busy_q, done_q;
	logic [1:0]   step_q;
	logic [127:0] acc_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;

	// select partial operands for this step
	always_comb begin
		pa = step_q[1] ? ua_q[63:32] : ua_q[31:0];
		pb = step_q[0] ? ub_q[63:32] : ub_q[31:0];
	end
	assign pp = {32'd0, pa} * {32'd0, pb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate shifted partial products
	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[63] ? -a : a;
			ub_q  <= b[63] ? -b : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + ({64'd0, pp} << (32 * (int'(step_q[1]) + int'(step_q[0]))));
		end
	end

	assign done = done_q;
	assign prod = neg_q ? -acc_q : acc_q;

endmodule

// File: rtl/core/incremental_weighted_line_fit_core.sv
// ----------------------------------------------------------------------------
// incremental_weighted_line_fit_core
// Sequence: a start folds its hit into the sums; an add or removal leaving two or
// more hits also solves each axis with six products and two divisions; a removal
// first walks the id list; full or ignored goes straight to the result.
// Throughput: one transaction in flight; the next waits until the result is taken.
// Reset: sums, count and parameters clear; floor becomes one; id list undefined.
// ----------------------------------------------------------------------------
module incremental_weighted_line_fit_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   operation,
	input  logic [15:0]  hit_id,
	input  logic signed [20:0] hit_x,
	input  logic signed [20:0] hit_y,
	input  logic signed [20:0] hit_z,
	input  logic [15:0]  weight_x,
	input  logic [15:0]  weight_y,
	output logic         out_valid,
	input  logic         out_stall,
	output logic signed [31:0] intercept_x,
	output logic signed [23:0] slope_x,
	output logic signed [31:0] intercept_y,
	output logic signed [23:0] slope_y,
	output logic [5:0]   hit_count,
	output logic [1:0]   status,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);
	import iwlf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_SHIFT, S_ACC, S_MUL, S_MULW, S_DEN, S_DIV, S_DIVW, S_OUT
	} state_t;

	state_t state_q, state_d;

	// captured item
	logic [1:0]  op_q;
	logic [15:0] id_q;
	logic signed [20:0] x_q, y_q, z_q;
	logic [15:0] wx_q, wy_q;

	// accumulators: [0] x axis, [1] y axis
	logic [23:0] s0_q [2];
	logic [43:0] sv_q [2];
	logic [43:0] sz_q [2];
	logic [63:0] svz_q [2];
	logic [63:0] szz_q [2];

	logic [15:0]   list_q [MaxHits];
	logic [CntW-1:0] total_q;
	logic [IdxW-1:0] idx_q;
	logic          idx_last;
	logic [31:0]   par_q [4];
	logic [31:0]   floor_q;
	logic [1:0]    st_q;

	// product sequencer
	logic [3:0]    mstep_q;
	logic          axis_q;
	logic [127:0]  prod;
	logic          mstart, mdone;
	logic [63:0]   ma, mb;
	logic [127:0]  t_q [6];
	logic [127:0]  den_q, sn_q, in_q;
	logic [1:0]    dstep_q;
	div_req_t      dreq;
	div_rsp_t      drsp;

	// per-hit terms
	logic signed [63:0] wv, wz, tvz, tzz;
	logic [15:0]        wgt;
	logic signed [20:0] vv;
	logic signed [63:0] zz;
	logic          sub;

	iwlf_mul u_mul (.clk, .arst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod);
	iwlf_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));

	assign in_stall  = (state_q != S_IDLE) || out_valid;
	assign cfg_ready = (state_q == S_IDLE);

	// last live list entry reached
	assign idx_last = (CntW'(idx_q) + CntW'(1)) >= total_q;

	// sign-extend sums for the solve
	logic signed [63:0] e_s0, e_sv, e_sz, e_svz, e_szz;
	always_comb begin
		e_s0  = 64'(signed'(s0_q[axis_q]));
		e_sv  = 64'(signed'(sv_q[axis_q]));
		e_sz  = 64'(signed'(sz_q[axis_q]));
		e_svz = svz_q[axis_q];
		e_szz = szz_q[axis_q];
	end

	// hit terms; small products are narrow, w*v*z kept to 64 bits
	always_comb begin
		wgt = axis_q ? wy_q : wx_q;
		vv  = axis_q ? y_q : x_q;
		zz  = 64'(z_q);
		wv  = 64'($signed({1'b0, wgt}) * vv);
		wz  = 64'($signed({1'b0, wgt}) * z_q);
		tvz = t_q[0][63:0];
		tzz = t_q[1][63:0];
		sub = (op_q == OP_REMOVE);
	end

	// multiplier operand select per step
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (mstep_q)
			4'd0: begin ma = wv;    mb = zz;   end
			4'd1: begin ma = wz;    mb = zz;   end
			4'd2: begin ma = e_szz; mb = e_s0; end
			4'd3: begin ma = e_sz;  mb = e_sz; end
			4'd4: begin ma = e_svz; mb = e_s0; end
			4'd5: begin ma = e_sv;  mb = e_sz; end
			4'd6: begin ma = e_sv;  mb = e_szz; end
			4'd7: begin ma = e_svz; mb = e_sz; end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign mstart = (state_q == S_MUL);

	// divider request
	logic [127:0] mag, dd;
	always_comb begin
		mag = den_q[127] ? -den_q : den_q;
		dd  = ((mag[127:32] == '0 && mag[31:0] < floor_q) || mag == '0) ? 128'd1 : den_q;
		dreq.start  = (state_q == S_DIV);
		dreq.den    = dd;
		dreq.narrow = (dstep_q == 2'd0);
		dreq.num    = (dstep_q == 2'd0) ? (sn_q << 20) : in_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid && !in_stall) begin
				unique case (operation)
					OP_START:  state_d = S_ACC;
					OP_ADD:    state_d = (total_q >= CntW'(MaxHits)) ? S_OUT : S_ACC;
					OP_REMOVE: state_d = (total_q == '0) ? S_OUT : S_SEARCH;
					default:   state_d = S_OUT;
				endcase
			end
			S_SEARCH: if (list_q[idx_q] == id_q) state_d = S_SHIFT;
				else if (idx_last) state_d = S_OUT;
			S_SHIFT: if (idx_last) state_d = S_ACC;
			// skip the solve when too few hits remain
			S_ACC:   state_d = (mstep_q == 4'd2 && axis_q && total_q <= CntW'(1)) ?
				S_OUT : S_MUL;
			S_MUL:   state_d = S_MULW;
			S_MULW:  if (mdone) begin
				if (mstep_q == 4'd1) state_d = S_ACC;
				else if (mstep_q == 4'd7) state_d = S_DEN;
				else state_d = S_MUL;
			end
			S_DEN:   state_d = S_DIV;
			S_DIV:   state_d = S_DIVW;
			S_DIVW:  if (drsp.done) begin
				if (dstep_q == 2'd1) state_d = axis_q ? S_OUT : S_MUL;
				else state_d = S_DIV;
			end
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			floor_q <= 32'd1;
			total_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				s0_q[i] <= '0; sv_q[i] <= '0; sz_q[i] <= '0;
				svz_q[i] <= '0; szz_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) par_q[i] <= '0;
			mstep_q <= '0;
			axis_q  <= 1'b0;
			dstep_q <= '0;
			idx_q   <= '0;
			st_q    <= ST_FEW;
		end else begin
			state_q <= state_d;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) floor_q <= cfg_data;
			unique case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					idx_q <= '0; mstep_q <= '0; axis_q <= 1'b0;
					if (operation == OP_ADD && total_q >= CntW'(MaxHits)) st_q <= ST_FULL;
					else if (operation == OP_REMOVE && total_q == '0) st_q <= ST_NOTFOUND;
					else st_q <= ST_FEW;
					if (operation == OP_START) begin
						for (int i = 0; i < 2; i++) begin
							s0_q[i] <= '0; sv_q[i] <= '0; sz_q[i] <= '0;
							svz_q[i] <= '0; szz_q[i] <= '0;
						end
						total_q <= CntW'(1);
					end else if (operation == OP_ADD && total_q < CntW'(MaxHits))
						total_q <= total_q + 1'b1;
				end
				// walk the list for the earliest matching id
				S_SEARCH: if (list_q[idx_q] != id_q) begin
					if (idx_last) st_q <= ST_NOTFOUND;
					else idx_q <= idx_q + 1'b1;
				end
				// close the gap, then drop the last entry
				S_SHIFT: if (idx_last) total_q <= total_q - 1'b1;
					else idx_q <= idx_q + 1'b1;
				S_ACC: if (mstep_q == 4'd2) begin
					// fold this axis' hit terms into the sums
					s0_q[axis_q]  <= sub ? s0_q[axis_q] - 24'(wgt) : s0_q[axis_q] + 24'(wgt);
					sv_q[axis_q]  <= sub ? sv_q[axis_q] - 44'(wv) : sv_q[axis_q] + 44'(wv);
					sz_q[axis_q]  <= sub ? sz_q[axis_q] - 44'(wz) : sz_q[axis_q] + 44'(wz);
					svz_q[axis_q] <= sub ? svz_q[axis_q] - tvz : svz_q[axis_q] + tvz;
					szz_q[axis_q] <= sub ? szz_q[axis_q] - tzz : szz_q[axis_q] + tzz;
					if (!axis_q) begin
						axis_q <= 1'b1; mstep_q <= '0;
					end else begin
						axis_q <= 1'b0;
						if (total_q > CntW'(1)) st_q <= ST_SOLVED;
						else mstep_q <= 4'd15;
					end
				end
				S_MULW: if (mdone) begin
					t_q[mstep_q[2:0] - ((mstep_q >= 4'd2) ? 3'd2 : 3'd0)] <= prod;
					mstep_q <= mstep_q + 4'd1;
				end
				S_DEN: begin
					den_q <= t_q[0] - t_q[1];
					sn_q  <= t_q[2] - t_q[3];
					in_q  <= t_q[4] - t_q[5];
					dstep_q <= '0;
				end
				S_DIVW: if (drsp.done) begin
					if (dstep_q == 2'd0) par_q[{axis_q, 1'b1}] <= drsp.quot;
					else begin
						par_q[{axis_q, 1'b0}] <= drsp.quot;
						axis_q <= 1'b1;
						mstep_q <= 4'd2;
					end
					dstep_q <= dstep_q + 2'd1;
				end
				S_OUT: out_valid <= 1'b1;
				default: ;
			endcase
		end
	end

	// id list
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) begin
			id_q <= hit_id; op_q <= operation;
			x_q <= hit_x; y_q <= hit_y; z_q <= hit_z;
			wx_q <= weight_x; wy_q <= weight_y;
			if (operation == OP_START) list_q[0] <= hit_id;
			else if (operation == OP_ADD && total_q < CntW'(MaxHits))
				list_q[total_q[IdxW-1:0]] <= hit_id;
		end
		if (state_q == S_SHIFT && !idx_last)
			list_q[idx_q] <= list_q[idx_q + 1'b1];
	end

	assign intercept_x = par_q[0];
	assign slope_x     = par_q[1][23:0];
	assign intercept_y = par_q[2];
	assign slope_y     = par_q[3][23:0];
	assign hit_count   = 6'(total_q);
	assign status      = st_q;

	ap_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_IDLE || state_q == S_OUT) else $error("busy with result");
	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CntW'(MaxHits)) else $error("count overflow");
	ap_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> state_q == S_IDLE) else $error("cfg while busy");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the incremental weighted line fit core. A generator
// builds track sequences (start, adds, removals, noise) into a pending queue;
// a clocked driver feeds them and predicts each fit, a clocked monitor checks
// every result transaction field by field. The determinant floor is changed
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import iwlf_pkg::*;

	typedef struct {
		op_t                op;
		logic [15:0]        id;
		logic signed [20:0] x, y, z;
		logic [15:0]        wx, wy;
	} hit_item_t;

	typedef struct {
		logic signed [31:0] icpt_x;
		logic signed [23:0] slope_x;
		logic signed [31:0] icpt_y;
		logic signed [23:0] slope_y;
		logic [5:0]         count;
		status_t            st;
	} fit_result_t;

	typedef struct {
		logic [23:0] s0;
		logic [43:0] sv, sz;
		logic [63:0] svz, szz;
	} axis_sums_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] operation;
	logic [15:0] hit_id, weight_x, weight_y;
	logic signed [20:0] hit_x, hit_y, hit_z;
	logic signed [31:0] intercept_x, intercept_y;
	logic signed [23:0] slope_x, slope_y;
	logic [5:0] hit_count;
	logic [1:0] status;
	logic cfg_valid, cfg_ready;
	logic [31:0] cfg_data;

	incremental_weighted_line_fit_core uut (.*);

	// predictor state
	logic [31:0] det_floor;
	axis_sums_t  trk_x = '{default: '0};
	axis_sums_t  trk_y = '{default: '0};
	logic [15:0] id_list[$];
	logic signed [31:0] held_icpt_x = '0;
	logic signed [31:0] held_icpt_y = '0;
	logic signed [23:0] held_slope_x = '0;
	logic signed [23:0] held_slope_y = '0;

	hit_item_t   pending_hits[$];
	fit_result_t expected_fits[$];
	hit_item_t   shadow_hits[$];   // generator's view of the track
	hit_item_t   cur_hit;
	int errors, items_sent, fits_checked, solved_seen, full_seen, missing_seen;
	int in_gap, out_gap, idle_cycles;
	bit quiet;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
			fits_checked);
	endtask

	function automatic longint clamp_quot(logic signed [127:0] q, int bits);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (q > hi) return longint'(hi);
		if (q < lo) return longint'(lo);
		return longint'(q);
	endfunction

	// solve one weighted straight line v = a + b z
	task automatic solve_line(input axis_sums_t s, output logic signed [31:0] icpt,
			output logic signed [23:0] slope);
		logic signed [127:0] s0, sv, sz, svz, szz, den, mag, snum, inum;
		s0  = $signed(s.s0);
		sv  = $signed(s.sv);
		sz  = $signed(s.sz);
		svz = $signed(s.svz);
		szz = $signed(s.szz);
		den  = szz * s0 - sz * sz;
		snum = (svz * s0 - sv * sz) <<< 20;
		inum = sv * szz - svz * sz;
		mag = (den < 0) ? -den : den;
		if (den == 0 || mag < $signed({96'd0, det_floor}))
			den = 1;
		slope = 24'(clamp_quot(snum / den, 24));
		icpt  = 32'(clamp_quot(inum / den, 32));
	endtask

	task automatic accumulate(inout axis_sums_t s, input bit sub, input logic [15:0] w,
			input logic signed [20:0] v, input logic signed [20:0] z);
		longint lw, lv, lz, t0, t1, t2, t3, t4;
		lw = w; lv = v; lz = z;
		t0 = lw; t1 = lw * lv; t2 = lw * lz; t3 = lw * lv * lz; t4 = lw * lz * lz;
		if (sub) begin
			t0 = -t0; t1 = -t1; t2 = -t2; t3 = -t3; t4 = -t4;
		end
		s.s0  = s.s0 + 24'(t0);
		s.sv  = s.sv + 44'(t1);
		s.sz  = s.sz + 44'(t2);
		s.svz = s.svz + 64'(t3);
		s.szz = s.szz + 64'(t4);
	endtask

	// work out the fit that one accepted hit transaction should produce
	task automatic fit_step(input hit_item_t h);
		fit_result_t r;
		int pos;
		r.st = ST_FEW;
		pos = -1;
		case (h.op)
			OP_START: begin
				trk_x = '{default: '0};
				trk_y = '{default: '0};
				id_list = {h.id};
				accumulate(trk_x, 0, h.wx, h.x, h.z);
				accumulate(trk_y, 0, h.wy, h.y, h.z);
			end
			OP_ADD: begin
				if (id_list.size() >= MaxHits) begin
					r.st = ST_FULL;
				end else begin
					id_list = {id_list, h.id};
					accumulate(trk_x, 0, h.wx, h.x, h.z);
					accumulate(trk_y, 0, h.wy, h.y, h.z);
					pos = 0;
				end
			end
			OP_REMOVE: begin
				foreach (id_list[i])
					if (pos < 0 && id_list[i] == h.id) pos = i;
				if (pos < 0) begin
					r.st = ST_NOTFOUND;
				end else begin
					id_list.delete(pos);
					accumulate(trk_x, 1, h.wx, h.x, h.z);
					accumulate(trk_y, 1, h.wy, h.y, h.z);
				end
			end
			default: ;
		endcase
		if (pos >= 0 && id_list.size() > 1) begin
			solve_line(trk_x, held_icpt_x, held_slope_x);
			solve_line(trk_y, held_icpt_y, held_slope_y);
			r.st = ST_SOLVED;
		end
		r.icpt_x = held_icpt_x; r.slope_x = held_slope_x;
		r.icpt_y = held_icpt_y; r.slope_y = held_slope_y;
		r.count = 6'(id_list.size());
		expected_fits = {expected_fits, r};
	endtask

	// drive hit transactions from the pending queue
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				fit_step(cur_hit);
				items_sent++;
				if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 13);
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_hits.size() > 0) begin
					cur_hit = pending_hits.pop_front();
					in_valid  <= 1'b1;
					operation <= cur_hit.op;
					hit_id    <= cur_hit.id;
					hit_x     <= cur_hit.x;
					hit_y     <= cur_hit.y;
					hit_z     <= cur_hit.z;
					weight_x  <= cur_hit.wx;
					weight_y  <= cur_hit.wy;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end else begin
			// hold the input side idle during reset
			in_valid  <= 1'b0;
			operation <= '0;
			hit_id    <= '0;
			hit_x     <= '0;
			hit_y     <= '0;
			hit_z     <= '0;
			weight_x  <= '0;
			weight_y  <= '0;
		end
	end

	// stall the result side in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 11) == 0) out_gap = $urandom_range(1, 13);
			end
		end else begin
			out_stall <= 1'b0;
		end
	end

	// check each result transaction against the oldest expectation
	always @(posedge clk) begin
		fit_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_fits.size() == 0) begin
				report("unexpected result transaction", 1, 0);
			end else begin
				e = expected_fits.pop_front();
				if (intercept_x !== e.icpt_x) report("intercept_x", intercept_x, e.icpt_x);
				if (slope_x !== e.slope_x) report("slope_x", slope_x, e.slope_x);
				if (intercept_y !== e.icpt_y) report("intercept_y", intercept_y, e.icpt_y);
				if (slope_y !== e.slope_y) report("slope_y", slope_y, e.slope_y);
				if (hit_count !== e.count) report("hit_count", hit_count, e.count);
				if (status !== e.st) report("status", status, e.st);
				if (e.st == ST_SOLVED) solved_seen++;
				if (e.st == ST_FULL) full_seen++;
				if (e.st == ST_NOTFOUND) missing_seen++;
			end
			fits_checked++;
		end
	end

	// watchdog: count cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 20000) begin
			$display("timeout with %0d results outstanding", expected_fits.size());
			$display("incremental_weighted_line_fit_core verification failed");
			$finish;
		end
	end

	// queue a hit and keep the generator's copy of the track in step
	task automatic queue_hit(op_t op, logic [15:0] id, logic signed [20:0] x,
			logic signed [20:0] y, logic signed [20:0] z, logic [15:0] wx, logic [15:0] wy);
		hit_item_t h;
		int pos;
		h = '{op, id, x, y, z, wx, wy};
		pending_hits = {pending_hits, h};
		pos = -1;
		case (op)
			OP_START: shadow_hits = {h};
			OP_ADD: if (shadow_hits.size() < MaxHits) shadow_hits = {shadow_hits, h};
			OP_REMOVE: begin
				foreach (shadow_hits[i])
					if (pos < 0 && shadow_hits[i].id == id) pos = i;
				if (pos >= 0) shadow_hits.delete(pos);
			end
			default: ;
		endcase
	endtask

	function automatic logic signed [20:0] any21();
		return 21'($urandom());
	endfunction

	// a hit near a random straight line, or anywhere
	task automatic queue_track_hit(op_t op, logic [15:0] id, int ax, int bx, int ay, int by);
		int z;
		logic [15:0] wx, wy;
		z  = $urandom_range(0, 2000000) - 1000000;
		wx = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 400));
		wy = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 400));
		if ($urandom_range(0, 9) == 0)
			queue_hit(op, id, any21(), any21(), any21(), wx, wy);
		else
			queue_hit(op, id, 21'(ax + ((longint'(bx) * z) >>> 20) + $urandom_range(0, 60) - 30),
				21'(ay + ((longint'(by) * z) >>> 20) + $urandom_range(0, 60) - 30),
				21'(z), wx, wy);
	endtask

	// one track: start, then adds mixed with removals and noise
	task automatic queue_track();
		int ax, bx, ay, by, n, pool;
		hit_item_t h;
		ax = $urandom_range(0, 200000) - 100000;
		ay = $urandom_range(0, 200000) - 100000;
		bx = $urandom_range(0, 2000000) - 1000000;
		by = $urandom_range(0, 2000000) - 1000000;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
		pool = ($urandom_range(0, 3) == 0) ? 4 : 65535;   // small pool forces duplicate ids
		queue_track_hit(OP_START, 16'($urandom_range(0, pool)), ax, bx, ay, by);
		repeat (n) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: if (shadow_hits.size() > 0) begin
					h = shadow_hits[$urandom_range(0, shadow_hits.size() - 1)];
					queue_hit(OP_REMOVE, h.id, h.x, h.y, h.z, h.wx, h.wy);
				end
				4: queue_track_hit(OP_REMOVE, 16'($urandom_range(0, pool)), ax, bx, ay, by);
				5: queue_hit(OP_NONE, 16'($urandom()), any21(), any21(), any21(),
					16'($urandom()), 16'($urandom()));
				default: queue_track_hit(OP_ADD, 16'($urandom_range(0, pool)), ax, bx, ay, by);
			endcase
		end
	endtask

	task automatic write_floor(logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		det_floor = v;
		cfg_valid <= 1'b0;
	endtask

	// wait until every queued transaction has been driven and checked
	task automatic drain();
		do @(negedge clk);
		while (pending_hits.size() != 0 || in_valid || expected_fits.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		logic [31:0] floors[5];
		arst_n = 1'b0;
		cfg_valid = 0; cfg_data = 0;
		det_floor = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every operation, duplicates, unknown and mismatched removals
		write_floor(32'd1);
		queue_hit(OP_ADD, 16'h0000, 21'sd5, 21'sd7, 21'sd0, 16'd1, 16'd1);
		queue_hit(OP_REMOVE, 16'hFFFF, 21'sd0, 21'sd0, 21'sd0, 16'd1, 16'd1);
		queue_hit(OP_START, 16'hFFFF, -21'sd1048576, 21'sd1048575, -21'sd1048576,
			16'hFFFF, 16'hFFFF);
		queue_hit(OP_ADD, 16'h0000, 21'sd1048575, -21'sd1048576, 21'sd1048575,
			16'hFFFF, 16'hFFFF);
		queue_hit(OP_ADD, 16'h0000, 21'sd100, 21'sd200, 21'sd0, 16'd0, 16'd0);
		queue_hit(OP_REMOVE, 16'h0000, 21'sd1048575, -21'sd1048576, 21'sd1048575,
			16'hFFFF, 16'hFFFF);
		queue_hit(OP_REMOVE, 16'h1234, 21'sd0, 21'sd0, 21'sd0, 16'd3, 16'd3);
		queue_hit(OP_NONE, 16'hAAAA, 21'sd1, 21'sd2, 21'sd3, 16'h5555, 16'hAAAA);
		queue_hit(OP_START, 16'd7, 21'sd10, 21'sd20, 21'sd1000, 16'd5, 16'd5);
		queue_hit(OP_ADD, 16'd8, 21'sd10, 21'sd20, 21'sd1000, 16'd5, 16'd5);
		queue_hit(OP_ADD, 16'd9, 21'sd30, 21'sd40, 21'sd3000, 16'd5, 16'd5);
		queue_hit(OP_REMOVE, 16'd9, 21'sd31, 21'sd39, 21'sd2999, 16'd6, 16'd4);
		queue_hit(OP_REMOVE, 16'd8, 21'sd10, 21'sd20, 21'sd1000, 16'd5, 16'd5);
		queue_hit(OP_REMOVE, 16'd7, 21'sd10, 21'sd20, 21'sd1000, 16'd5, 16'd5);
		queue_hit(OP_ADD, 16'd1, 21'sd0, 21'sd0, 21'sd0, 16'd1, 16'd1);
		drain();

		// random phases across determinant floor settings, extremes included
		floors = '{32'd0, 32'hFFFFFFFF, 32'd1, $urandom(), 32'd1000};
		foreach (floors[p]) begin
			write_floor(floors[p]);
			if (p == 4) quiet = 1;
			while (pending_hits.size() + items_sent < 320 * (p + 1) + 15) queue_track();
			drain();
		end

		repeat (20) @(posedge clk);
		$display("%0d hit transactions, %0d results: %0d solved, %0d list full, %0d not found",
			items_sent, fits_checked, solved_seen, full_seen, missing_seen);
		$display("five determinant floor settings, random stalls on both sides");
		if (errors == 0)
			$display("incremental_weighted_line_fit_core verification clean");
		else
			$display("incremental_weighted_line_fit_core verification failed");
		$finish;
	end
endmodule

// File: incremental_weighted_line_fit_core.f
rtl/core/iwlf_pkg.sv
rtl/core/iwlf_div.sv
rtl/core/iwlf_mul.sv
rtl/core/incremental_weighted_line_fit_core.sv
sim/tb_top.sv
